[hdl/rdl_pkg.sv]
// Package for the resource directory lookup block.
// Holds transfer payload types, command codes, controller types and constants.
// No dependencies.
package rdl_pkg;

  // Command codes of the input channel; code 3 is ignored.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_code_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  localparam logic [15:0] TERMINATOR_ID = 16'hFFFF;
  localparam int          TYPE_SHIFT    = 11;
  localparam int          WIN_VOL_SHIFT = 28;
  localparam int          DOS_VOL_SHIFT = 26;
  localparam int          ENTRY_W       = 48;

  // Input item.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] entry_id;
    logic [31:0] entry_location;
    logic [4:0]  query_type;
    logic [10:0] query_number;
    logic [5:0]  preferred_volume;
  } cmd_item_t;

  // Result item.
  typedef struct packed {
    logic        found;
    logic        exact_volume;
    logic [27:0] location_offset;
    logic [5:0]  volume_number;
    logic        table_overflow;
  } rsp_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic load;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

[hdl/rdl_if.sv]
// Valid/ready channel interfaces for commands and results.
// Depends on rdl_pkg for the payload types.
interface rdl_cmd_if;
  import rdl_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rdl_rsp_if;
  import rdl_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/rdl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rdl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/rdl_ctrl.sv]
// Controller for the resource directory lookup: command decode, scan
// sequencing and the result output register handshake. Depends on rdl_pkg.
module rdl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rdl_pkg::dp_status_t status,
  output rdl_pkg::ctrl_cmd_t  ctl
);
  import rdl_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            CMD_CLEAR:  ctl.clear  = 1'b1;
            CMD_APPEND: ctl.append = 1'b1;
            CMD_LOOKUP: begin
              ctl.start  = 1'b1;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // result register must be free or draining this cycle
        if (status.scan_done && (!out_valid || out_ready)) begin
          ctl.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output valid: set on load, cleared on transfer
  always_comb begin
    out_valid_next = out_valid;
    if (ctl.load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

[hdl/rdl_datapath.sv]
// Datapath for the resource directory lookup: entry store, fill count,
// table flags, scan pipeline and result register. Depends on rdl_pkg, rdl_ram.
module rdl_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  rdl_pkg::ctrl_cmd_t  ctl,
  input  rdl_pkg::cmd_item_t  item,
  output rdl_pkg::dp_status_t status,
  output rdl_pkg::rsp_item_t  result
);
  import rdl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [CW-1:0]      count;
  logic               closed;
  logic               ovf;
  logic               win;
  logic [15:0]        qid;
  logic [5:0]         pvol;
  logic [CW-1:0]      issue_idx;
  logic               pend;
  logic               scanning;
  logic               found;
  logic               exact;
  logic [27:0]        roff;
  logic [5:0]         rvol;

  logic               we;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  logic [15:0]        e_id;
  logic [31:0]        e_loc;
  logic [27:0]        e_off;
  logic [5:0]         e_vol;
  logic               hit;

  // store write: open table, not terminator, room left
  assign we = ctl.append && !closed && (item.entry_id != TERMINATOR_ID) && (count < DEPTH_C);

  // one read per cycle until the last stored entry or an exact hit
  assign rd_en = scanning && !exact && (issue_idx < count);

  rdl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata ({item.entry_id, item.entry_location}),
    .re    (rd_en),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_data)
  );

  // split the returned entry by the format chosen by entry 0
  always_comb begin
    e_id  = rd_data[ENTRY_W-1:32];
    e_loc = rd_data[31:0];
    if (win) begin
      e_off = e_loc[27:0];
      e_vol = {2'b00, e_loc[31:WIN_VOL_SHIFT]};
    end else begin
      e_off = {2'b00, e_loc[25:0]};
      e_vol = e_loc[31:DOS_VOL_SHIFT];
    end
    hit = scanning && pend && !exact && (e_id == qid);
  end

  assign status.scan_done = scanning && (exact || (!pend && (issue_idx >= count)));

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      closed <= 1'b0;
      ovf    <= 1'b0;
    end else if (ctl.clear) begin
      count  <= '0;
      closed <= 1'b0;
      ovf    <= 1'b0;
    end else if (ctl.append && !closed) begin
      if (item.entry_id == TERMINATOR_ID) begin
        closed <= 1'b1;
      end else if (count >= DEPTH_C) begin
        ovf <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // location format follows entry 0
  always_ff @(posedge clk) begin
    if (we && (count == '0)) begin
      win <= (item.entry_location[31:WIN_VOL_SHIFT] != 4'd0);
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      pend     <= 1'b0;
    end else begin
      pend <= rd_en;
      if (ctl.start) begin
        scanning <= 1'b1;
      end else if (ctl.load) begin
        scanning <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      qid       <= {item.query_type, item.query_number};
      pvol      <= item.preferred_volume;
      issue_idx <= '0;
      found     <= 1'b0;
      exact     <= 1'b0;
      roff      <= '0;
      rvol      <= '0;
    end else begin
      if (rd_en) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (hit) begin
        found <= 1'b1;
        roff  <= e_off;
        rvol  <= e_vol;
        if (e_vol == pvol) begin
          exact <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      result.found           <= found;
      result.exact_volume    <= exact;
      result.location_offset <= roff;
      result.volume_number   <= rvol;
      result.table_overflow  <= ovf;
    end
  end

endmodule

[hdl/resource_directory_lookup.sv]
// Top level of the resource directory lookup block.
// Depends on rdl_pkg, rdl_if, rdl_ctrl, rdl_datapath, rdl_ram.
//
//   channel | dir | payload      | transfer
//   --------+-----+--------------+------------------
//   cmd     | in  | cmd_item_t   | cmd.valid & cmd.ready
//   rsp     | out | rsp_item_t   | rsp.valid & rsp.ready
//
// Clear and append leave the controller idle. A lookup reads the n stored
// entries, one store read per cycle through the single read port, each
// through the registered read, and ends early on an exact-volume hit.
// Reset is synchronous; the store is not cleared, a fill count bounds reads.
// A lookup result waits in an output register; commands are taken meanwhile,
// but a following lookup finishes only once the result register is free.
module resource_directory_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic       clk,
  input logic       rst,
  rdl_cmd_if.sink   cmd,
  rdl_rsp_if.source rsp
);
  import rdl_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t status;

  rdl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_command (cmd.data.command),
    .in_ready   (cmd.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .status     (status),
    .ctl        (ctl)
  );

  rdl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (cmd.data),
    .status (status),
    .result (rsp.data)
  );

endmodule

[hdl/rdl_checker.sv]
// Port-level checks for resource_directory_lookup, attached by bind.
// Depends on rdl_pkg for payload types.
module rdl_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rdl_pkg::rsp_item_t out_data
);
  import rdl_pkg::*;

  // not found reports all-zero location fields
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |->
      (!out_data.exact_volume && out_data.location_offset == 28'd0 &&
       out_data.volume_number == 6'd0))
    else $error("not-found result with nonzero fields");

  // exact volume implies a match
  a_exact_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.exact_volume) |-> out_data.found)
    else $error("exact volume without found");

  // a new result only comes out of a scan, during which commands stall
  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a scan");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

endmodule

bind resource_directory_lookup rdl_checker u_rdl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (cmd.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_data  (rsp.data)
);

[verif/tb_resource_directory_lookup.sv]
// Self-checking testbench for resource_directory_lookup: directed and random command streams.
// Keeps its own copy of the directory and predicts every lookup answer.
// Depends on rdl_pkg, rdl_if and the resource_directory_lookup RTL.
module tb_resource_directory_lookup;
  import rdl_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          DEPTH        = 1024;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          RANDOM_ITEMS = 400;
  localparam logic [1:0]  CMD_IGNORED  = 2'd3;

  typedef struct {
    cmd_item_t item;
    int        gap;
  } backlog_entry_t;

  logic clk = 1'b0;
  logic rst;

  rdl_cmd_if cmd_ch ();
  rdl_rsp_if rsp_ch ();

  resource_directory_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Commands waiting for the driver and lookup answers waiting for the block.
  backlog_entry_t command_backlog [$];
  rsp_item_t      lookup_answers [$];

  // Shadow directory.
  logic [15:0] dir_id  [DEPTH];
  logic [31:0] dir_loc [DEPTH];
  int          dir_count;
  bit          dir_closed;
  bit          dir_overflow;

  // Bookkeeping.
  int mismatch_count = 0;
  int commands_taken = 0;
  int answers_seen   = 0;
  int answers_found  = 0;
  int answers_exact  = 0;
  int answers_ovf    = 0;
  int generated      = 0;
  int hold_request   = 0;

  // Sender pacing state (generator side).
  bit tx_calm      = 1'b0;
  int tx_calm_left = 0;

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_item_t random_fields(input logic [1:0] code);
    cmd_item_t c;
    c.command          = code;
    c.entry_id         = 16'($urandom_range(0, 65535));
    c.entry_location   = $urandom;
    c.query_type       = 5'($urandom_range(0, 31));
    c.query_number     = 11'($urandom_range(0, 2047));
    c.preferred_volume = 6'($urandom_range(0, 63));
    return c;
  endfunction

  task automatic push_command(input cmd_item_t c, input bit no_gap);
    backlog_entry_t e;
    if (tx_calm_left == 0) begin
      tx_calm      = !tx_calm;
      tx_calm_left = $urandom_range(10, 60);
    end
    tx_calm_left--;
    e.item = c;
    e.gap  = (no_gap || tx_calm) ? 0 : pick_gap();
    command_backlog.push_back(e);
    if (c.command != CMD_IGNORED) generated++;
  endtask

  task automatic queue_clear(input bit no_gap);
    push_command(random_fields(CMD_CLEAR), no_gap);
  endtask

  task automatic queue_append(input logic [15:0] id, input logic [31:0] loc, input bit no_gap);
    cmd_item_t c;
    c                = random_fields(CMD_APPEND);
    c.entry_id       = id;
    c.entry_location = loc;
    push_command(c, no_gap);
  endtask

  task automatic queue_lookup(input logic [15:0] id, input logic [5:0] pvol, input bit no_gap);
    cmd_item_t c;
    c                  = random_fields(CMD_LOOKUP);
    c.query_type       = id[15:11];
    c.query_number     = id[10:0];
    c.preferred_volume = pvol;
    push_command(c, no_gap);
  endtask

  // Apply one accepted command to the shadow directory; a lookup yields an answer.
  task automatic apply_command(input cmd_item_t c);
    logic [15:0] qid;
    logic [27:0] off;
    logic [5:0]  vol;
    rsp_item_t   ans;
    bit          win;
    case (c.command)
      CMD_CLEAR: begin
        dir_count    = 0;
        dir_closed   = 1'b0;
        dir_overflow = 1'b0;
      end
      CMD_APPEND: begin
        if (!dir_closed) begin
          if (c.entry_id == TERMINATOR_ID) begin
            dir_closed = 1'b1;
          end else if (dir_count >= DEPTH) begin
            dir_overflow = 1'b1;
          end else begin
            dir_id[dir_count]  = c.entry_id;
            dir_loc[dir_count] = c.entry_location;
            dir_count++;
          end
        end
      end
      CMD_LOOKUP: begin
        qid = {c.query_type, c.query_number};
        ans = '0;
        // Entry 0 decides how every location word is split.
        win = (dir_count > 0) && (dir_loc[0][31:28] != 4'd0);
        for (int i = 0; i < dir_count && !ans.exact_volume; i++) begin
          if (dir_id[i] == qid) begin
            if (win) begin
              off = dir_loc[i][27:0];
              vol = {2'b00, dir_loc[i][31:28]};
            end else begin
              off = {2'b00, dir_loc[i][25:0]};
              vol = dir_loc[i][31:26];
            end
            ans.found           = 1'b1;
            ans.location_offset = off;
            ans.volume_number   = vol;
            ans.exact_volume    = (vol == c.preferred_volume);
          end
        end
        ans.table_overflow = dir_overflow;
        lookup_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endtask

  // Compare one result transfer with the oldest predicted answer.
  task automatic check_answer(input rsp_item_t got);
    rsp_item_t exp;
    if (lookup_answers.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: found=%0b exact=%0b off=%h vol=%0d ovf=%0b",
                 got.found, got.exact_volume, got.location_offset, got.volume_number,
                 got.table_overflow);
    end else begin
      exp = lookup_answers.pop_front();
      answers_seen++;
      if (exp.found) answers_found++;
      if (exp.exact_volume) answers_exact++;
      if (exp.table_overflow) answers_ovf++;
      if (got.found !== exp.found || got.exact_volume !== exp.exact_volume ||
          got.location_offset !== exp.location_offset ||
          got.volume_number !== exp.volume_number ||
          got.table_overflow !== exp.table_overflow) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"mismatch on answer %0d: expected found=%0b exact=%0b off=%h vol=%0d ",
                    "ovf=%0b, got found=%0b exact=%0b off=%h vol=%0d ovf=%0b"},
                   answers_seen, exp.found, exp.exact_volume, exp.location_offset,
                   exp.volume_number, exp.table_overflow, got.found, got.exact_volume,
                   got.location_offset, got.volume_number, got.table_overflow);
      end
    end
  endtask

  // Command driver: after each transfer, idle for the gap stored with the item.
  backlog_entry_t head;
  int             idle_left;

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data  <= '0;
      idle_left    <= 0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (idle_left > 0) begin
        cmd_ch.valid <= 1'b0;
        idle_left    <= idle_left - 1;
      end else if (command_backlog.size() > 0) begin
        head = command_backlog.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= head.item;
        idle_left    <= head.gap;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, calm stretches, and one long hold on request.
  bit rx_calm;
  int rx_calm_left;
  int rx_stall_left;
  int hold_left;
  int hold_seen;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready  <= 1'b0;
      rx_calm       <= 1'b0;
      rx_calm_left  <= 0;
      rx_stall_left <= 0;
      hold_left     <= 0;
      hold_seen     <= 0;
    end else begin
      rx_calm_left <= (rx_calm_left == 0) ? $urandom_range(50, 300) : rx_calm_left - 1;
      if (rx_calm_left == 0) rx_calm <= !rx_calm;
      if (hold_seen != hold_request) begin
        hold_seen    <= hold_request;
        hold_left    <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        rsp_ch.ready  <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        rx_stall_left <= pick_gap();
        rsp_ch.ready  <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check results first, then predict from the accepted command.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) check_answer(rsp_ch.data);
      if (cmd_ch.valid && cmd_ch.ready) begin
        commands_taken++;
        apply_command(cmd_ch.data);
      end
    end
  end

  // Watchdog: work outstanding but no transfer on either channel for too long.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (cmd_ch.valid || lookup_answers.size() > 0 || command_backlog.size() > 0) begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d answers outstanding",
                 stuck_cycles, lookup_answers.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (command_backlog.size() != 0 || cmd_ch.valid || lookup_answers.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id(input logic [15:0] pool [4]);
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 3)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [5:0] pick_vol(input logic [5:0] vols [$]);
    if (vols.size() > 0 && $urandom_range(0, 9) < 7)
      return vols[$urandom_range(0, vols.size() - 1)];
    return 6'($urandom_range(0, 63));
  endfunction

  // One well-formed table: clear, appends with interleaved lookups, maybe a terminator.
  task automatic queue_table(input int max_entries);
    logic [15:0] pool [4];
    logic [5:0]  vols [$];
    logic [31:0] loc;
    bit          win;
    int          n;
    queue_clear(1'b0);
    for (int k = 0; k < 4; k++) pool[k] = 16'($urandom_range(0, 65534));
    win = 1'($urandom_range(0, 1));
    n   = $urandom_range(0, max_entries);
    for (int i = 0; i < n; i++) begin
      loc = $urandom;
      if (i == 0) loc[31:28] = win ? 4'($urandom_range(1, 15)) : 4'd0;
      vols.push_back(loc[31:26]);
      vols.push_back({2'b00, loc[31:28]});
      queue_append(pool[$urandom_range(0, 3)], loc, 1'b0);
      if ($urandom_range(0, 3) == 0) queue_lookup(pick_id(pool), pick_vol(vols), 1'b0);
    end
    if ($urandom_range(0, 9) < 7) begin
      queue_append(TERMINATOR_ID, $urandom, 1'b0);
      repeat ($urandom_range(0, 2)) queue_append(pick_id(pool), $urandom, 1'b0);
    end
    repeat ($urandom_range(2, 6)) queue_lookup(pick_id(pool), pick_vol(vols), 1'b0);
  endtask

  initial begin
    int start_count;
    logic [15:0] big_pool [4];
    logic [31:0] loc;

    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, plain packing, extremes, fallback, terminator, ignored code.
    queue_lookup(16'h0000, 6'd0, 1'b0);
    queue_clear(1'b0);
    queue_append(16'h0000, 32'h0000_0000, 1'b0);
    queue_append(16'hFFFE, 32'hFFFF_FFFF, 1'b0);
    queue_append(16'h0000, {6'd5, 26'h2AA_AAAA}, 1'b0);
    queue_lookup(16'h0000, 6'd5, 1'b0);
    queue_lookup(16'h0000, 6'd7, 1'b0);
    queue_lookup(16'hFFFE, 6'd63, 1'b0);
    queue_append(TERMINATOR_ID, 32'h1234_5678, 1'b0);
    queue_append(16'h0001, 32'h0400_0001, 1'b0);
    queue_lookup(16'h0001, 6'd1, 1'b0);
    queue_lookup(16'hFFFF, 6'd63, 1'b0);
    push_command(random_fields(CMD_IGNORED), 1'b0);
    // Wide packing chosen by entry 0; a preferred volume above 15 cannot match.
    queue_clear(1'b0);
    queue_append(16'h1234, 32'hF000_0001, 1'b0);
    queue_append(16'h1234, 32'h3FFF_FFFF, 1'b0);
    queue_lookup(16'h1234, 6'd3, 1'b0);
    queue_lookup(16'h1234, 6'd40, 1'b0);
    queue_lookup(16'h1234, 6'd15, 1'b0);
    queue_clear(1'b0);
    queue_lookup(16'h1234, 6'd15, 1'b0);
    wait_drained();

    // Sender pauses until drained, then the receiver holds off while a burst arrives.
    @(negedge clk);
    hold_request++;
    queue_clear(1'b1);
    for (int i = 0; i < 6; i++) queue_append(16'(16'h0040 + i), $urandom, 1'b1);
    for (int i = 0; i < 10; i++)
      queue_lookup(16'(16'h0040 + (i % 7)), 6'($urandom_range(0, 63)), 1'b1);
    wait_drained();

    // Random: mostly well-formed tables, some noise.
    start_count = generated;
    while (generated - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        queue_table($urandom_range(0, 99) < 80 ? 8 : 40);
      end else begin
        repeat ($urandom_range(1, 4))
          push_command(random_fields(2'($urandom_range(0, 3))), 1'b0);
      end
    end

    // Fill past the store depth once.
    queue_clear(1'b0);
    for (int k = 0; k < 4; k++) big_pool[k] = 16'($urandom_range(0, 65534));
    for (int i = 0; i < DEPTH + 3; i++) begin
      loc = $urandom;
      if (i == 0) loc[31:28] = 4'd0;
      queue_append(big_pool[$urandom_range(0, 3)], loc, 1'b1);
    end
    queue_lookup(big_pool[0], 6'($urandom_range(0, 63)), 1'b0);
    queue_lookup(big_pool[1], 6'($urandom_range(0, 3)), 1'b0);
    queue_append(TERMINATOR_ID, $urandom, 1'b0);
    queue_lookup(16'hFFFF, 6'd0, 1'b0);
    queue_clear(1'b0);
    queue_lookup(big_pool[2], 6'd0, 1'b0);

    wait_drained();
    repeat (DEPTH + 16) @(posedge clk);

    $display("run covered %0d accepted commands and %0d lookup answers", commands_taken,
             answers_seen);
    $display("answers: %0d found, %0d on preferred volume, %0d with overflow set",
             answers_found, answers_exact, answers_ovf);
    if (mismatch_count == 0 && lookup_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d answers never arrived", mismatch_count,
               lookup_answers.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
